// ----- rtl/ajb_pkg.sv -----
package ajb_pkg;

    // operation codes carried in s_tuser[0]
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // register indexes
    localparam logic REG_PRIME_THRESHOLD = 1'b0;
    localparam logic REG_MAX_FILL        = 1'b1;

    localparam int unsigned CFG_W    = 15;
    localparam int unsigned SAMPLE_W = 16;

    localparam logic [CFG_W-1:0] PRIME_THRESHOLD_RST = 15'd2400;
    localparam logic [CFG_W-1:0] MAX_FILL_RST        = 15'd12000;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic push;
        logic pull;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
    } t_status;

endpackage

// ----- rtl/ajb_ctrl.sv -----
module ajb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_operation,
    input  logic            i_m_tready,
    input  ajb_pkg::t_status i_status,
    output logic            o_s_tready,
    output ajb_pkg::t_cmd   o_cmd
);

    ajb_pkg::t_state r_state;
    ajb_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_s_tvalid && (r_state == ajb_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ajb_pkg::ST_IDLE: begin
                if (w_accept && (i_operation == ajb_pkg::OP_PULL)) begin
                    n_state = ajb_pkg::ST_LOAD;
                end
            end
            ajb_pkg::ST_LOAD: begin
                if (!i_status.out_valid || i_m_tready) begin
                    n_state = ajb_pkg::ST_IDLE;
                end
            end
            default: n_state = ajb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ajb_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.push = w_accept && (i_operation == ajb_pkg::OP_PUSH);
                o_cmd.pull = w_accept && (i_operation == ajb_pkg::OP_PULL);
            end
            ajb_pkg::ST_LOAD: begin
                // memory data is ready; move it into the output slot once free
                o_cmd.load = !i_status.out_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ajb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_accept_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ajb_pkg::ST_LOAD) |-> !o_s_tready)
        else $error("item accepted while a pull is in flight");

    a_pull_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pull |=> (r_state == ajb_pkg::ST_LOAD))
        else $error("pull did not enter load");

endmodule

// ----- rtl/ajb_dpath.sv -----
module ajb_dpath #(
    parameter int unsigned FIFO_DEPTH = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ajb_pkg::t_cmd        i_cmd,
    output ajb_pkg::t_status     o_status,
    input  logic [15:0]          i_s_tdata,
    input  logic [1:0]           i_s_tuser,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [15:0]          o_m_tdata,
    output logic [0:0]           o_m_tuser,
    output logic                 o_m_tlast,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    output logic [31:0]          o_cfg_rdata
);

    localparam int unsigned PW   = $clog2(FIFO_DEPTH);
    localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CMPW = (CW > ajb_pkg::CFG_W) ? CW : ajb_pkg::CFG_W;

    logic [ajb_pkg::SAMPLE_W-1:0] r_mem [FIFO_DEPTH];
    logic [ajb_pkg::SAMPLE_W-1:0] r_rd_data;

    logic [ajb_pkg::CFG_W-1:0] r_prime_threshold;
    logic [ajb_pkg::CFG_W-1:0] r_max_fill;

    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_primed, n_primed;
    logic          r_blocked, n_blocked;

    logic          r_pend_real;
    logic          r_pend_last;
    logic          r_out_valid;
    logic [15:0]   r_out_data;
    logic          r_out_real;
    logic          r_out_last;

    logic [CMPW-1:0] w_fill_ext;
    logic [CMPW-1:0] w_cap;
    logic [CMPW-1:0] w_drop;
    logic [CMPW:0]   w_rp_sum;
    logic [PW-1:0]   w_rp_inc;
    logic [PW-1:0]   w_wp_inc;
    logic            w_first;
    logic            w_served;
    logic            w_pop;
    logic [CW-1:0]   w_fill_after;
    logic [CW-1:0]   w_ptr_diff;

    assign w_first    = i_s_tuser[1];
    assign w_fill_ext = CMPW'(r_fill);
    assign w_rp_inc   = (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign w_wp_inc   = (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // fill cap: zero acts as one, anything beyond the store acts as the store depth
    always_comb begin
        w_cap = CMPW'(r_max_fill);
        if (w_cap == '0) begin
            w_cap = CMPW'(1);
        end else if (w_cap > CMPW'(FIFO_DEPTH)) begin
            w_cap = CMPW'(FIFO_DEPTH);
        end
    end

    assign w_drop   = w_fill_ext - w_cap + CMPW'(1);
    assign w_rp_sum = (CMPW+1)'(r_rp) + (CMPW+1)'(w_drop);

    always_comb begin
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_fill       = r_fill;
        n_primed     = r_primed;
        n_blocked    = r_blocked;
        w_served     = 1'b0;
        w_pop        = 1'b0;
        w_fill_after = r_fill;
        if (i_cmd.push) begin
            n_wp = w_wp_inc;
            if (w_fill_ext >= w_cap) begin
                // overrun: drop oldest so the fill after this write equals the cap
                if (w_rp_sum >= (CMPW+1)'(FIFO_DEPTH)) begin
                    n_rp = PW'(w_rp_sum - (CMPW+1)'(FIFO_DEPTH));
                end else begin
                    n_rp = PW'(w_rp_sum);
                end
                n_fill = CW'(w_cap);
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else if (i_cmd.pull) begin
            if (w_first) begin
                if (r_primed) begin
                    n_blocked = 1'b0;
                end else if (w_fill_ext >= CMPW'(r_prime_threshold)) begin
                    n_primed  = 1'b1;
                    n_blocked = 1'b0;
                end else begin
                    n_blocked = 1'b1;
                end
            end
            w_served = n_primed && !n_blocked;
            w_pop    = w_served && (r_fill != '0);
            if (w_pop) begin
                n_rp         = w_rp_inc;
                w_fill_after = r_fill - 1'b1;
            end
            n_fill = w_fill_after;
            if (i_s_tlast) begin
                if (w_served && (w_fill_after == '0)) begin
                    n_primed = 1'b0;
                end
                n_blocked = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp      <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_primed  <= 1'b0;
            r_blocked <= 1'b0;
        end else begin
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_primed  <= n_primed;
            r_blocked <= n_blocked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wp] <= i_s_tdata;
        end
        if (i_cmd.pull) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull) begin
            r_pend_real <= w_pop;
            r_pend_last <= i_s_tlast;
        end
        if (i_cmd.load) begin
            r_out_data <= r_pend_real ? r_rd_data : '0;
            r_out_real <= r_pend_real;
            r_out_last <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_data;
    assign o_m_tuser          = r_out_real;
    assign o_m_tlast          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_threshold <= ajb_pkg::PRIME_THRESHOLD_RST;
            r_max_fill        <= ajb_pkg::MAX_FILL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ajb_pkg::REG_PRIME_THRESHOLD: r_prime_threshold <= i_cfg_wdata[14:0];
                ajb_pkg::REG_MAX_FILL:        r_max_fill        <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_idx)
            ajb_pkg::REG_PRIME_THRESHOLD: o_cfg_rdata = {17'd0, r_prime_threshold};
            ajb_pkg::REG_MAX_FILL:        o_cfg_rdata = {17'd0, r_max_fill};
            default:                      o_cfg_rdata = '0;
        endcase
    end

    // distance from read to write pointer around the ring
    assign w_ptr_diff = (r_wp >= r_rp) ? (CW'(r_wp) - CW'(r_rp))
                                       : (CW'(r_wp) + CW'(FIFO_DEPTH) - CW'(r_rp));

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(FIFO_DEPTH))
        else $error("fill beyond store depth");

    a_fill_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == w_ptr_diff) || ((r_fill == CW'(FIFO_DEPTH)) && (w_ptr_diff == '0)))
        else $error("fill disagrees with pointers");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_fill != '0))
        else $error("store empty after push");

    a_last_unblocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pull && i_s_tlast) |=> !r_blocked)
        else $error("request still blocked after last item");

endmodule

// ----- rtl/audio_jitter_buffer_fifo.sv -----
// Audio capture jitter buffer. Push items (s_tuser[0]=0) write one signed 16-bit sample
// into a ring store of FIFO_DEPTH entries, dropping the oldest samples once the fill reaches
// max_fill. Pull items (s_tuser[0]=1) return one result each: the next stored sample, or
// silence (zero, m_tuser=0) while the buffer is not primed, while a request is held off, or
// on underrun. s_tuser[1] marks the first pull of a read request, s_tlast the last; the
// buffer primes at the first pull once the fill has reached prime_threshold and unprimes when
// the last pull of a served request leaves the store empty. A push completes in IDLE; a pull
// reads the sample memory through its registered read port, then waits in LOAD only while the
// one-entry output register is full and m_tready is low. No clearing pass
// is needed after reset. Registers: prime_threshold at 0x0, max_fill at 0x4, 15 bits each.
module audio_jitter_buffer_fifo #(
    parameter int unsigned FIFO_DEPTH = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_sample
    input  logic [1:0]  s_tuser,   // [0] operation, [1] first_of_read
    input  logic        s_tlast,   // last_of_read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] output_sample
    output logic [0:0]  m_tuser,   // [0] real_sample
    output logic        m_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ajb_pkg::t_cmd    w_cmd;
    ajb_pkg::t_status w_status;
    logic             w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    ajb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_operation (s_tuser[0]),
        .i_m_tready  (m_tready),
        .i_status    (w_status),
        .o_s_tready  (s_tready),
        .o_cmd       (w_cmd)
    );

    ajb_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_idx   (paddr[2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata)
    );

endmodule

// ----- bench/audio_jitter_buffer_fifo_test.sv -----
module audio_jitter_buffer_fifo_test;

    localparam int unsigned DEPTH = 16384;

    typedef struct packed {
        logic        op;
        logic [15:0] smp;
        logic        first;
        logic        lastm;
    } t_pcm_item;

    typedef struct packed {
        logic [15:0] smp;
        logic        from_fifo;
        logic        lastm;
    } t_pcm_out;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MASK,
        RX_SPARSE
    } t_rx_mode;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [15:0] capture_sample
    logic [1:0]  s_tuser  = '0;  // [0] operation, [1] first_of_read
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] output_sample
    logic [0:0]  m_tuser;        // [0] real_sample
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    audio_jitter_buffer_fifo uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // buffer model
    logic [15:0] buf_store [DEPTH];
    logic [13:0] buf_rd      = '0;
    logic [13:0] buf_wr      = '0;
    logic [14:0] buf_fill    = '0;
    logic        buf_primed  = 1'b0;
    logic        buf_blocked = 1'b0;
    logic [14:0] thr_reg     = ajb_pkg::PRIME_THRESHOLD_RST;
    logic [14:0] cap_reg     = ajb_pkg::MAX_FILL_RST;

    t_pcm_item item_feed[$];
    t_pcm_out  awaited_outputs[$];

    int unsigned items_sent     = 0;
    int unsigned items_taken    = 0;
    int unsigned outputs_seen   = 0;
    int unsigned popped_seen    = 0;
    int unsigned fail_count     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned config_writes  = 0;

    function automatic t_pcm_item take_feed_item();
        t_pcm_item it;
        it = item_feed[0];
        item_feed.delete(0);
        return it;
    endfunction

    function automatic t_pcm_out take_awaited_output();
        t_pcm_out res;
        res = awaited_outputs[0];
        awaited_outputs.delete(0);
        return res;
    endfunction

    function automatic void jitter_model_step(input t_pcm_item it);
        logic [14:0] cap;
        logic [14:0] drop;
        logic        served;
        t_pcm_out    res;
        if (it.op == ajb_pkg::OP_PUSH) begin
            cap = cap_reg;
            if (cap == 15'd0) cap = 15'd1;
            if (cap > DEPTH[14:0]) cap = DEPTH[14:0];
            if (buf_fill >= cap) begin
                drop = buf_fill - cap + 15'd1;
                buf_rd = buf_rd + drop[13:0];
                buf_fill = buf_fill - drop;
            end
            buf_store[buf_wr] = it.smp;
            buf_wr = buf_wr + 14'd1;
            buf_fill = buf_fill + 15'd1;
            return;
        end
        if (it.first) begin
            if (buf_primed) begin
                buf_blocked = 1'b0;
            end else if (buf_fill >= thr_reg) begin
                buf_primed = 1'b1;
                buf_blocked = 1'b0;
            end else begin
                buf_blocked = 1'b1;
            end
        end
        res = '0;
        served = buf_primed && !buf_blocked;
        if (served && buf_fill != 15'd0) begin
            res.smp = buf_store[buf_rd];
            res.from_fifo = 1'b1;
            buf_rd = buf_rd + 14'd1;
            buf_fill = buf_fill - 15'd1;
        end
        if (it.lastm) begin
            if (served && buf_fill == 15'd0) buf_primed = 1'b0;
            buf_blocked = 1'b0;
        end
        res.lastm = it.lastm;
        awaited_outputs.push_back(res);
    endfunction

    // sender: bursts of items with random gaps between them
    t_pcm_item   bus_item;
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                jitter_model_step(bus_item);
                items_taken++;
            end
            if (s_tvalid && !s_tready) begin
                stall_cycles++;
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (item_feed.size() > 0) begin
                bus_item = take_feed_item();
                s_tdata  <= bus_item.smp;
                s_tuser  <= {bus_item.first, bus_item.op};
                s_tlast  <= bus_item.lastm;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 31);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    logic        hold_asked = 1'b0;
    logic        hold_done  = 1'b0;
    int unsigned hold_left  = 0;
    logic [31:0] rx_tick    = '0;
    logic [7:0]  rx_mask    = '1;
    t_rx_mode    rx_mode    = RX_OPEN;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 299;
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick[5:0] == 6'd0) begin
                rx_mode = t_rx_mode'(2'($urandom_range(0, 3)));
                rx_mask = 8'($urandom);
            end
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                RX_MASK:  m_tready <= rx_mask[rx_tick[2:0]];
                default:  m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pcm_out got;
        t_pcm_out want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.smp       = m_tdata;
            got.from_fifo = m_tuser[0];
            got.lastm     = m_tlast;
            if (awaited_outputs.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected output item: sample %h real %b last %b",
                             got.smp, got.from_fifo, got.lastm);
            end else begin
                want = take_awaited_output();
                outputs_seen++;
                if (want.from_fifo) popped_seen++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("output %0d mismatch: expected %h/%b/%b got %h/%b/%b",
                                 outputs_seen, want.smp, want.from_fifo, want.lastm,
                                 got.smp, got.from_fifo, got.lastm);
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [14:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {17'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ajb_pkg::REG_PRIME_THRESHOLD) thr_reg = value;
        else cap_reg = value;
        config_writes++;
    endtask

    task automatic add_item(input logic op, input logic [15:0] smp,
                            input logic first, input logic lastm);
        t_pcm_item it;
        it.op    = op;
        it.smp   = smp;
        it.first = first;
        it.lastm = lastm;
        item_feed.push_back(it);
        items_sent++;
    endtask

    task automatic add_request(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            add_item(ajb_pkg::OP_PULL, 16'($urandom), k == 0, k == len - 1);
    endtask

    // mostly pushes and well-formed read requests, some stray markers
    task automatic add_random_phase(input int unsigned n);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = items_sent;
        while (items_sent - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = $urandom_range(1, 16);
                repeat (len) add_item(ajb_pkg::OP_PUSH, 16'($urandom),
                                      1'($urandom), 1'($urandom));
            end else if (pick < 85) begin
                add_request($urandom_range(1, 12));
            end else begin
                add_item(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // pushes give no result, so wait until every item is taken, not only until the last output
    task automatic settle();
        while (items_taken != items_sent || awaited_outputs.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [14:0] thr, input logic [14:0] cap);
        settle();
        write_reg(ajb_pkg::REG_PRIME_THRESHOLD, thr);
        write_reg(ajb_pkg::REG_MAX_FILL, cap);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, priming, overrun drop, underrun, unprime
        set_config(15'd3, 15'd6);
        add_item(ajb_pkg::OP_PUSH, 16'h7FFF, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h8000, 1'b1, 1'b1);
        add_item(ajb_pkg::OP_PUSH, 16'hFFFF, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h0001, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PULL, 16'hFFFF, 1'b0, 1'b0);   // no first marker, not primed
        add_item(ajb_pkg::OP_PULL, 16'h0000, 1'b1, 1'b0);
        add_item(ajb_pkg::OP_PULL, 16'h0000, 1'b0, 1'b1);   // fill left over, stays primed
        add_item(ajb_pkg::OP_PUSH, 16'h0100, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h0200, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h0300, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h0400, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'h0500, 1'b0, 1'b0);   // at cap: oldest dropped
        add_request(1);
        // cap lowered under the fill
        set_config(15'd3, 15'd2);
        add_item(ajb_pkg::OP_PUSH, 16'h5A5A, 1'b0, 1'b0);
        add_request(4);                            // runs into underrun, then unprimes
        add_request(1);                            // below threshold: blocked
        add_item(ajb_pkg::OP_PULL, 16'hA5A5, 1'b1, 1'b0);
        add_item(ajb_pkg::OP_PULL, 16'h0000, 1'b0, 1'b1);
        // zero threshold primes on an empty store; cap 0 behaves as 1
        set_config(15'd0, 15'd0);
        add_request(1);
        add_item(ajb_pkg::OP_PUSH, 16'h1234, 1'b0, 1'b0);
        add_item(ajb_pkg::OP_PUSH, 16'hEDCB, 1'b0, 1'b0);
        add_request(1);
        // threshold out of reach, cap above the depth
        set_config(15'h7FFF, 15'h7FFF);
        repeat (3) add_item(ajb_pkg::OP_PUSH, 16'($urandom), 1'b0, 1'b0);
        add_request(2);

        // threshold and cap at the store depth, then a long request that stays unprimed and gets silence
        set_config(DEPTH[14:0], DEPTH[14:0]);
        repeat (48) add_item(ajb_pkg::OP_PUSH, 16'($urandom), 1'($urandom), 1'($urandom));
        add_request(40);

        set_config(15'd8, 15'd32);
        add_random_phase(230);
        set_config(15'd0, 15'd5);
        add_random_phase(230);
        set_config(15'd20, 15'd64);
        add_random_phase(230);
        hold_asked = 1'b1;
        set_config(15'd4, 15'd1);
        add_random_phase(230);
        set_config(15'($urandom_range(0, 24)), 15'($urandom_range(0, 48)));
        add_random_phase(230);
        set_config(15'($urandom_range(0, 24)), 15'($urandom_range(0, 48)));
        add_random_phase(230);
        set_config(15'h7FFF, 15'd12);
        add_random_phase(230);
        settle();
        repeat (20) @(posedge i_clk);

        fail_count += awaited_outputs.size();
        $display("%0d input items over %0d register writes, %0d outputs checked",
                 items_sent, config_writes, outputs_seen);
        $display("%0d outputs from the store, %0d silent; input held off %0d cycles",
                 popped_seen, outputs_seen - popped_seen, stall_cycles);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
